// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of the block table.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFBT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RFBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rfbt_pkg.sv =====
// Package of the block table: widths, request and status codes, state
// encoding and the table entry type. Depends on nothing.
package rfbt_pkg;

    localparam int DEF_ENTRIES = 16;

    localparam logic [16:0] POOL_LIMIT = 17'h10000;
    localparam logic [15:0] REFS_MAX   = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_CREATE = 3'd0,
        OP_INC    = 3'd1,
        OP_DEC    = 3'd2,
        OP_SWEEP  = 3'd3,
        OP_XLATE  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_REFUSED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic [15:0] ident;
        logic [16:0] bytes;
        logic [15:0] base;
        logic [15:0] refs;
    } entry_t;

    typedef struct packed {
        logic hit;
        logic free_it;
    } eval_t;

endpackage

// ===== src/rfbt_table.sv =====
// Entry memory of the block table: one write port, one registered read port.
// Depends on rfbt_pkg for the entry type.
module rfbt_table
    import rfbt_pkg::*;
#(
    parameter int DEPTH = DEF_ENTRIES,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/rfbt_eval.sv =====
// Shared entry evaluator: the one compare and offset adder that every scan
// step of the sequencer uses. Depends on rfbt_pkg.
module rfbt_eval
    import rfbt_pkg::*;
#(
    parameter int OFFW = 22
)
(
    input  logic [2:0]      op,
    input  logic            used,
    input  entry_t          ent,
    input  logic [15:0]     req_id,
    input  logic [16:0]     req_size,
    input  logic [OFFW-1:0] offset,
    output eval_t           result,
    output logic [OFFW-1:0] offset_sum
);

    always_comb
    begin
        result = '0;
        case (op)
            OP_CREATE:
            begin
                result.hit = !used && (ent.bytes >= req_size);
            end
            OP_INC, OP_DEC, OP_XLATE:
            begin
                result.hit = used && (ent.ident == req_id);
            end
            OP_SWEEP:
            begin
                result.free_it = used && (ent.refs == 16'd0);
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    // Running offset of the create walk.
    assign offset_sum = offset + OFFW'(ent.bytes);

endmodule

// ===== src/refcounted_first_fit_block_table_unit.sv =====
// Sequence: done rises after the scan has read the entries up to and including a hit (at
// most TABLE_ENTRIES, 16 by default) and the apply state has run; an unknown request code
// skips the scan and goes straight to the apply state.
// Throughput: one item at a time; a new item is taken in the cycle of the result.
// Set by the single read port of the entry memory, one entry per cycle.
// Reset: asynchronous and active low; empties the table, pool back to 65536.
module refcounted_first_fit_block_table_unit
    import rfbt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [15:0] block_id,
    input  logic [16:0] req_size,
    output logic        done,
    output logic        ok,
    output logic [1:0]  status,
    output logic [15:0] result_id,
    output logic [15:0] base_offset,
    output logic [4:0]  freed_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);

    // Index width, count width (holds TABLE_ENTRIES itself) and the width of
    // the summed offset, which can pass the pool limit on a long walk.
    localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
    localparam int OFFW = 17 + CNTW;

    // Sequencer state and bookkeeping.
    state_t                  state_reg, state_next;
    logic [16:0]             pool_reg;
    logic [CNTW-1:0]         filled_reg, filled_next;
    logic [15:0]             next_id_reg, next_id_next;
    logic [TABLE_ENTRIES-1:0] used_reg, used_next;

    // The item being served.
    logic [2:0]              op_reg, op_next;
    logic [15:0]             id_reg, id_next;
    logic [16:0]             size_reg, size_next;

    // Scan pointers: iss_reg is the next entry to read, cur_reg the entry whose
    // data sits in the memory's read register when pend_reg is set.
    logic [CNTW-1:0]         iss_reg, iss_next;
    logic [IDXW-1:0]         cur_reg, cur_next;
    logic                    pend_reg, pend_next;
    logic [OFFW-1:0]         offset_reg, offset_next;
    logic [4:0]              freed_reg, freed_next;
    logic                    found_reg, found_next;
    logic [IDXW-1:0]         hit_idx_reg, hit_idx_next;
    entry_t                  hold_reg, hold_next;

    // Result registers.
    logic                    done_reg, done_next;
    logic                    ok_reg, ok_next;
    logic [1:0]              status_reg, status_next;
    logic [15:0]             rid_reg, rid_next;
    logic [15:0]             base_reg, base_next;
    logic [4:0]              fout_reg, fout_next;

    // Memory ports and evaluator.
    logic                    rd_en;
    logic [IDXW-1:0]         rd_addr;
    entry_t                  rd_data;
    logic                    wr_en;
    logic [IDXW-1:0]         wr_addr;
    entry_t                  wr_data;
    eval_t                   ev;
    logic [OFFW-1:0]         ev_offset;

    logic                    accept;
    logic                    scan_hit;
    logic                    scan_more;
    logic [16:0]             pool_eff;
    logic [17:0]             end_sum;
    logic                    app_ok;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign scan_hit  = pend_reg && ev.hit;
    assign scan_more = (iss_reg < filled_reg);

    // Pool register values above the limit behave as the limit.
    assign pool_eff = (pool_reg > POOL_LIMIT) ? POOL_LIMIT : pool_reg;
    // Only used when the offset is already below the limit, so 17 bits of it do.
    assign end_sum  = {1'b0, offset_reg[16:0]} + {1'b0, size_reg};
    assign app_ok   = (filled_reg < CNTW'(TABLE_ENTRIES))
                   && (offset_reg < OFFW'(POOL_LIMIT))
                   && (end_sum <= {1'b0, pool_eff});

    rfbt_table #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDXW)
    ) u_table (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    rfbt_eval #(
        .OFFW (OFFW)
    ) u_eval (
        .op         (op_reg),
        .used       (used_reg[cur_reg]),
        .ent        (rd_data),
        .req_id     (id_reg),
        .req_size   (size_reg),
        .offset     (offset_reg),
        .result     (ev),
        .offset_sum (ev_offset)
    );

    // Next state. Every known request walks the table; an unknown code goes
    // straight to the answer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type inside {[OP_CREATE:OP_XLATE]})
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_APPLY;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_hit || !scan_more)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs of the sequencer.
    always_comb
    begin
        filled_next  = filled_reg;
        next_id_next = next_id_reg;
        used_next    = used_reg;
        op_next      = op_reg;
        id_next      = id_reg;
        size_next    = size_reg;
        iss_next     = iss_reg;
        cur_next     = cur_reg;
        pend_next    = pend_reg;
        offset_next  = offset_reg;
        freed_next   = freed_reg;
        found_next   = found_reg;
        hit_idx_next = hit_idx_reg;
        hold_next    = hold_reg;
        done_next    = 1'b0;
        ok_next      = ok_reg;
        status_next  = status_reg;
        rid_next     = rid_reg;
        base_next    = base_reg;
        fout_next    = fout_reg;
        rd_en        = 1'b0;
        rd_addr      = iss_reg[IDXW-1:0];
        wr_en        = 1'b0;
        wr_addr      = hit_idx_reg;
        wr_data      = hold_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = req_type;
                    id_next     = block_id;
                    size_next   = req_size;
                    iss_next    = '0;
                    pend_next   = 1'b0;
                    offset_next = '0;
                    freed_next  = '0;
                    found_next  = 1'b0;
                end
            end

            S_SCAN:
            begin
                if (scan_hit)
                begin
                    // Keep the entry; no further read is issued.
                    found_next   = 1'b1;
                    hold_next    = rd_data;
                    hit_idx_next = cur_reg;
                    pend_next    = 1'b0;
                end
                else
                begin
                    if (pend_reg)
                    begin
                        offset_next = ev_offset;
                        if (ev.free_it)
                        begin
                            used_next[cur_reg] = 1'b0;
                            freed_next         = freed_reg + 5'd1;
                        end
                    end
                    if (scan_more)
                    begin
                        rd_en     = 1'b1;
                        cur_next  = iss_reg[IDXW-1:0];
                        pend_next = 1'b1;
                        iss_next  = iss_reg + CNTW'(1);
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end
            end

            S_APPLY:
            begin
                done_next   = 1'b1;
                ok_next     = 1'b0;
                status_next = ST_REFUSED;
                rid_next    = '0;
                base_next   = '0;
                fout_next   = '0;
                case (op_reg)
                    OP_CREATE:
                    begin
                        if (found_reg)
                        begin
                            // Reuse a free slot; it keeps its own size.
                            wr_en                  = 1'b1;
                            wr_addr                = hit_idx_reg;
                            wr_data.ident          = next_id_reg;
                            wr_data.bytes          = hold_reg.bytes;
                            wr_data.base           = offset_reg[15:0];
                            wr_data.refs           = 16'd1;
                            used_next[hit_idx_reg] = 1'b1;
                            next_id_next           = next_id_reg + 16'd1;
                            ok_next                = 1'b1;
                            status_next            = ST_OK;
                            rid_next               = next_id_reg;
                            base_next              = offset_reg[15:0];
                        end
                        else if (app_ok)
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = filled_reg[IDXW-1:0];
                            wr_data.ident = next_id_reg;
                            wr_data.bytes = size_reg;
                            wr_data.base  = offset_reg[15:0];
                            wr_data.refs  = 16'd1;
                            used_next[filled_reg[IDXW-1:0]] = 1'b1;
                            filled_next   = filled_reg + CNTW'(1);
                            next_id_next  = next_id_reg + 16'd1;
                            ok_next       = 1'b1;
                            status_next   = ST_OK;
                            rid_next      = next_id_reg;
                            base_next     = offset_reg[15:0];
                        end
                        else
                        begin
                            status_next = ST_NOSPACE;
                        end
                    end
                    OP_INC:
                    begin
                        if (found_reg)
                        begin
                            wr_en = 1'b1;
                            if (hold_reg.refs != REFS_MAX)
                            begin
                                wr_data.refs = hold_reg.refs + 16'd1;
                            end
                            ok_next     = 1'b1;
                            status_next = ST_OK;
                        end
                        else
                        begin
                            status_next = ST_NOTFOUND;
                        end
                    end
                    OP_DEC:
                    begin
                        if (!found_reg)
                        begin
                            status_next = ST_NOTFOUND;
                        end
                        else if (hold_reg.refs != 16'd0)
                        begin
                            wr_en        = 1'b1;
                            wr_data.refs = hold_reg.refs - 16'd1;
                            ok_next      = 1'b1;
                            status_next  = ST_OK;
                        end
                    end
                    OP_SWEEP:
                    begin
                        ok_next     = 1'b1;
                        status_next = ST_OK;
                        fout_next   = freed_reg;
                    end
                    OP_XLATE:
                    begin
                        if (!found_reg)
                        begin
                            status_next = ST_NOTFOUND;
                        end
                        else if (size_reg <= hold_reg.bytes)
                        begin
                            ok_next     = 1'b1;
                            status_next = ST_OK;
                            base_next   = hold_reg.base;
                        end
                    end
                    default:
                    begin
                        status_next = ST_REFUSED;
                    end
                endcase
            end

            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control state, initialised by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pool_reg    <= POOL_LIMIT;
            filled_reg  <= '0;
            next_id_reg <= '0;
            used_reg    <= '0;
            pend_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            filled_reg  <= filled_next;
            next_id_reg <= next_id_next;
            used_reg    <= used_next;
            pend_reg    <= pend_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                pool_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        id_reg      <= id_next;
        size_reg    <= size_next;
        iss_reg     <= iss_next;
        cur_reg     <= cur_next;
        offset_reg  <= offset_next;
        freed_reg   <= freed_next;
        found_reg   <= found_next;
        hit_idx_reg <= hit_idx_next;
        hold_reg    <= hold_next;
        ok_reg      <= ok_next;
        status_reg  <= status_next;
        rid_reg     <= rid_next;
        base_reg    <= base_next;
        fout_reg    <= fout_next;
    end

    assign done        = done_reg;
    assign ok          = ok_reg;
    assign status      = status_reg;
    assign result_id   = rid_reg;
    assign base_offset = base_reg;
    assign freed_count = fout_reg;

endmodule

// ===== src/rfbt_checker.sv =====
// Port-level checker for the block table, bound to the top level.
// Depends on rfbt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rfbt_checker
    import rfbt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        ok,
    input logic [1:0]  status,
    input logic [15:0] result_id,
    input logic [15:0] base_offset,
    input logic [4:0]  freed_count
);

    logic accepted;
    logic status_ok;
    logic refused;
    logic data_zero;

    assign accepted  = start && !busy;
    assign status_ok = (status == ST_OK);
    assign refused   = done && !status_ok;
    assign data_zero = (result_id == 16'd0) && (base_offset == 16'd0)
                    && (freed_count == 5'd0);

    `RFBT_ASSERT_NEXT(a_accept_busy, clk, rst_n, accepted, busy, "accepted item not busy")
    `RFBT_ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy, "result shown while busy")
    `RFBT_ASSERT_IMPL(a_ok_status, clk, rst_n, done, ok == status_ok, "ok and status disagree")
    `RFBT_ASSERT_IMPL(a_refused_zero, clk, rst_n, refused, data_zero, "refused item carries data")
    `RFBT_ASSERT_IMPL(a_end_done, clk, rst_n, $fell(busy), done, "item ended without result")

endmodule

bind refcounted_first_fit_block_table_unit rfbt_checker u_rfbt_checker (.*);

// ===== verif/refcounted_first_fit_block_table_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the reference-counted first-fit block table.
// Depends on rfbt_pkg and refcounted_first_fit_block_table_unit.
module refcounted_first_fit_block_table_unit_tb
    import rfbt_pkg::*;
();

    localparam int SLOTS         = DEF_ENTRIES;
    // Extra wait after every answer is back, before a pool write and at the end of the run.
    localparam int SETTLE_CYCLES = 25;
    // The run is abandoned after this many cycles with no item, answer or pool write.
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 290;
    localparam int PHASES        = 6;

    // Request codes that the block does not know. It must refuse them and change nothing.
    localparam logic [2:0] OP_UNDEF_LO = 3'd5;
    localparam logic [2:0] OP_UNDEF_HI = 3'd7;

    typedef struct packed {
        logic        ok;
        status_t     status;
        logic [15:0] result_id;
        logic [15:0] base_offset;
        logic [4:0]  freed_count;
    } answer_t;

    // One row of the directed script. It is either a request or a write of the pool size.
    typedef struct {
        bit          pool_write;
        logic [2:0]  kind;
        logic [15:0] ident;
        logic [16:0] bytes;
        bit          known;
        answer_t     want;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  req_type;
    logic [15:0] block_id;
    logic [16:0] req_size;
    logic        done;
    logic        ok;
    logic [1:0]  status;
    logic [15:0] result_id;
    logic [15:0] base_offset;
    logic [4:0]  freed_count;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [16:0] cfg_data;

    // The testbench keeps its own copy of the block table. It is updated in step with every
    // item that the block accepts.
    bit          tbl_used  [SLOTS];
    logic [15:0] tbl_ident [SLOTS];
    logic [16:0] tbl_bytes [SLOTS];
    logic [15:0] tbl_base  [SLOTS];
    logic [15:0] tbl_refs  [SLOTS];
    int          tbl_filled;
    logic [15:0] ident_next;
    logic [16:0] pool_reg;

    answer_t     answers_due[$];
    script_row_t script[$];
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    int          answers_seen = 0;

    always #2 clk = ~clk;

    refcounted_first_fit_block_table_unit #(
        .TABLE_ENTRIES(SLOTS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .block_id    (block_id),
        .req_size    (req_size),
        .done        (done),
        .ok          (ok),
        .status      (status),
        .result_id   (result_id),
        .base_offset (base_offset),
        .freed_count (freed_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    function automatic answer_t make_answer(logic a_ok, status_t a_status, logic [15:0] a_id,
                                            logic [15:0] a_base, logic [4:0] a_freed);
        answer_t a;
        a.ok          = a_ok;
        a.status      = a_status;
        a.result_id   = a_id;
        a.base_offset = a_base;
        a.freed_count = a_freed;
        return a;
    endfunction

    // Lookups take the lowest filled entry that is in use and carries the id. This matters
    // once ids have wrapped.
    function automatic int find_slot(logic [15:0] ident);
        for (int i = 0; i < tbl_filled; i++)
        begin
            if (tbl_used[i] && tbl_ident[i] == ident)
                return i;
        end
        return -1;
    endfunction

    function automatic void claim_slot(int slot, logic [16:0] bytes, logic [15:0] base);
        tbl_used[slot]  = 1'b1;
        tbl_ident[slot] = ident_next;
        tbl_bytes[slot] = bytes;
        tbl_base[slot]  = base;
        tbl_refs[slot]  = 16'd1;
        ident_next      = ident_next + 16'd1;
    endfunction

    // Works out the block's answer to one request and applies the request to the table copy.
    function automatic answer_t table_answer(logic [2:0] kind, logic [15:0] ident,
                                             logic [16:0] bytes);
        int         slot;
        int         offset;
        int         pool_eff;
        logic [4:0] freed;
        logic [15:0] granted;
        case (kind)
            OP_CREATE:
            begin
                // Values of the register above the pool limit behave as the limit itself.
                pool_eff = (pool_reg > POOL_LIMIT) ? int'(POOL_LIMIT) : int'(pool_reg);
                offset   = 0;
                // First fit: a free entry keeps its own size when it is reused, so the running
                // sum of sizes stays consistent. Its base becomes that running sum.
                for (int i = 0; i < tbl_filled; i++)
                begin
                    if (!tbl_used[i] && tbl_bytes[i] >= bytes)
                    begin
                        granted = ident_next;
                        claim_slot(i, tbl_bytes[i], 16'(offset));
                        return make_answer(1'b1, ST_OK, granted, 16'(offset), 5'd0);
                    end
                    offset += int'(tbl_bytes[i]);
                end
                // Otherwise the new block is appended at the end. An append whose offset
                // would already be at or past the pool limit is refused, even when it is empty.
                if (tbl_filled < SLOTS && offset < int'(POOL_LIMIT)
                    && offset + int'(bytes) <= pool_eff)
                begin
                    granted = ident_next;
                    claim_slot(tbl_filled, bytes, 16'(offset));
                    tbl_filled++;
                    return make_answer(1'b1, ST_OK, granted, 16'(offset), 5'd0);
                end
                return make_answer(1'b0, ST_NOSPACE, 16'd0, 16'd0, 5'd0);
            end
            OP_INC:
            begin
                slot = find_slot(ident);
                if (slot < 0)
                    return make_answer(1'b0, ST_NOTFOUND, 16'd0, 16'd0, 5'd0);
                // The count saturates at its maximum, and the increase still succeeds.
                if (tbl_refs[slot] != REFS_MAX)
                    tbl_refs[slot] = tbl_refs[slot] + 16'd1;
                return make_answer(1'b1, ST_OK, 16'd0, 16'd0, 5'd0);
            end
            OP_DEC:
            begin
                slot = find_slot(ident);
                if (slot < 0)
                    return make_answer(1'b0, ST_NOTFOUND, 16'd0, 16'd0, 5'd0);
                if (tbl_refs[slot] == 16'd0)
                    return make_answer(1'b0, ST_REFUSED, 16'd0, 16'd0, 5'd0);
                tbl_refs[slot] = tbl_refs[slot] - 16'd1;
                return make_answer(1'b1, ST_OK, 16'd0, 16'd0, 5'd0);
            end
            OP_SWEEP:
            begin
                // Freed entries stay in the table as free slots. Only their used mark drops.
                freed = 5'd0;
                for (int i = 0; i < tbl_filled; i++)
                begin
                    if (tbl_used[i] && tbl_refs[i] == 16'd0)
                    begin
                        tbl_used[i] = 1'b0;
                        freed       = freed + 5'd1;
                    end
                end
                return make_answer(1'b1, ST_OK, 16'd0, 16'd0, freed);
            end
            OP_XLATE:
            begin
                slot = find_slot(ident);
                if (slot < 0)
                    return make_answer(1'b0, ST_NOTFOUND, 16'd0, 16'd0, 5'd0);
                if (bytes > tbl_bytes[slot])
                    return make_answer(1'b0, ST_REFUSED, 16'd0, 16'd0, 5'd0);
                return make_answer(1'b1, ST_OK, 16'd0, tbl_base[slot], 5'd0);
            end
            default:
                return make_answer(1'b0, ST_REFUSED, 16'd0, 16'd0, 5'd0);
        endcase
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("tb: mismatch at answer %0d, %0t: %s", answers_seen, $realtime, what);
    endtask

    // Results are sampled at the rising edge that ends their one-cycle strobe. The same
    // process also runs the watchdog. Every accepted item, answer or register write counts
    // as progress.
    always @(posedge clk)
    begin : check_answers
        answer_t want;
        if (rst_n === 1'b1)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else if (done === 1'b1)
            begin
                answers_seen++;
                if (answers_due.size() == 0)
                    report_mismatch("answer arrived with no item outstanding");
                else
                begin
                    want = answers_due.pop_front();
                    if (ok !== want.ok)
                        report_mismatch($sformatf("ok %b, expected %b", ok, want.ok));
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                    if (result_id !== want.result_id)
                        report_mismatch($sformatf("result_id %0d, expected %0d",
                                                  result_id, want.result_id));
                    if (base_offset !== want.base_offset)
                        report_mismatch($sformatf("base_offset %0d, expected %0d",
                                                  base_offset, want.base_offset));
                    if (freed_count !== want.freed_count)
                        report_mismatch($sformatf("freed_count %0d, expected %0d",
                                                  freed_count, want.freed_count));
                end
            end
        end
    end

    function automatic void add_request(logic [2:0] kind, logic [15:0] ident,
                                        logic [16:0] bytes, bit known, answer_t want);
        script_row_t row;
        row.pool_write = 1'b0;
        row.kind       = kind;
        row.ident      = ident;
        row.bytes      = bytes;
        row.known      = known;
        row.want       = want;
        script.insert(script.size(), row);
    endfunction

    function automatic void add_pool_write(logic [16:0] value);
        script_row_t row;
        row.pool_write = 1'b1;
        row.kind       = OP_CREATE;
        row.ident      = 16'd0;
        row.bytes      = value;
        row.known      = 1'b0;
        row.want       = '0;
        script.insert(script.size(), row);
    endfunction

    // The caller enters at a falling edge and leaves at a falling edge. Start is raised
    // here and left high, so that a following item in the same burst goes out back to back.
    // A typed answer replaces the computed one, but the table copy is always updated.
    task automatic send_item(logic [2:0] kind, logic [15:0] ident, logic [16:0] bytes,
                             bit known, answer_t want);
        answer_t computed;
        start    <= 1'b1;
        req_type <= kind;
        block_id <= ident;
        req_size <= bytes;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        computed = table_answer(kind, ident, bytes);
        answers_due.insert(answers_due.size(), known ? want : computed);
        @(negedge clk);
    endtask

    // Stops sending and waits until every answer is back, then for some extra cycles.
    // A falling edge always passes first, so that start is never lowered and raised again
    // in the same time step.
    task automatic settle(int extra);
        start <= 1'b0;
        do
            @(negedge clk);
        while (answers_due.size() != 0);
        repeat (extra) @(negedge clk);
    endtask

    task automatic idle_for(int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    // The register is only written while the block is idle.
    task automatic write_pool(logic [16:0] value);
        settle(SETTLE_CYCLES);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        pool_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random requests are mostly well formed. Ids are taken from the table, and sizes are
    // near the sizes of existing entries, fill the pool exactly or stay small against the
    // pool. A minority are noise: random ids, sizes over the whole field and undefined codes.
    task automatic pick_request(output logic [2:0] kind, output logic [15:0] ident,
                                output logic [16:0] bytes);
        int roll;
        int sub;
        int slot;
        int pool_eff;
        int used_bytes;
        roll       = $urandom_range(0, 99);
        sub        = $urandom_range(0, 99);
        slot       = (tbl_filled > 0) ? $urandom_range(0, tbl_filled - 1) : 0;
        ident      = (tbl_filled > 0 && $urandom_range(0, 99) < 85) ? tbl_ident[slot]
                                                                    : 16'($urandom);
        bytes      = 17'($urandom);
        pool_eff   = (pool_reg > POOL_LIMIT) ? int'(POOL_LIMIT) : int'(pool_reg);
        used_bytes = 0;
        for (int i = 0; i < tbl_filled; i++)
            used_bytes += int'(tbl_bytes[i]);
        if (roll < 30)
        begin
            kind = OP_CREATE;
            if (sub < 10)
                bytes = 17'd0;
            else if (sub < 25)
                bytes = tbl_bytes[slot] + 17'($urandom_range(0, 1));
            else if (sub < 33 && used_bytes < pool_eff)
                bytes = 17'(pool_eff - used_bytes);
            else if (sub >= 40)
                bytes = 17'($urandom_range(0, (pool_eff / 6 > 8) ? pool_eff / 6 : 8));
        end
        else if (roll < 45)
            kind = OP_INC;
        else if (roll < 63)
            kind = OP_DEC;
        else if (roll < 70)
            kind = OP_SWEEP;
        else if (roll < 92)
        begin
            kind = OP_XLATE;
            if (sub >= 55)
                bytes = 17'($urandom_range(0, int'(tbl_bytes[slot])));
            else if (sub >= 15)
                bytes = tbl_bytes[slot] + 17'($urandom_range(0, 1));
        end
        else if (roll < 96)
            kind = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        else
            kind = 3'($urandom_range(0, 7));
    endtask

    // Sender bursts have a random length and are separated by random gaps, some of them
    // empty. Now and then the sender waits until every answer is back.
    task automatic run_random(int count);
        int          burst;
        logic [2:0]  kind;
        logic [15:0] ident;
        logic [16:0] bytes;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst == 0)
            begin
                if ($urandom_range(0, 39) == 0)
                    settle(0);
                else
                    idle_for($urandom_range(0, 7));
                burst = $urandom_range(1, 40);
            end
            pick_request(kind, ident, bytes);
            send_item(kind, ident, bytes, 1'b0, '0);
            burst--;
        end
    endtask

    initial
    begin : stimulus
        logic [16:0] phase_pool [PHASES];
        rst_n     = 1'b0;
        start     = 1'b0;
        req_type  = OP_CREATE;
        block_id  = 16'd0;
        req_size  = 17'd0;
        cfg_valid = 1'b0;
        cfg_data  = 17'd0;

        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_used[i]  = 1'b0;
            tbl_ident[i] = 16'd0;
            tbl_bytes[i] = 17'd0;
            tbl_base[i]  = 16'd0;
            tbl_refs[i]  = 16'd0;
        end
        tbl_filled = 0;
        ident_next = 16'd0;
        pool_reg   = POOL_LIMIT;

        // The directed script starts from an empty table with the full pool. Answers are
        // typed in where they are obvious. The last few rows are left to the predictor.
        add_request(OP_XLATE, 16'd0, 17'd0, 1'b1, make_answer(0, ST_NOTFOUND, 0, 0, 0));
        add_request(OP_INC, 16'hFFFF, 17'd0, 1'b1, make_answer(0, ST_NOTFOUND, 0, 0, 0));
        add_request(OP_SWEEP, 16'd0, 17'd0, 1'b1, make_answer(1, ST_OK, 0, 0, 0));
        add_request(OP_UNDEF_LO, 16'hFFFF, 17'h1FFFF, 1'b1,
                    make_answer(0, ST_REFUSED, 0, 0, 0));
        add_request(OP_CREATE, 16'd0, 17'h1FFFF, 1'b1, make_answer(0, ST_NOSPACE, 0, 0, 0));
        add_request(OP_CREATE, 16'd0, 17'd0, 1'b1, make_answer(1, ST_OK, 0, 0, 0));
        // With an empty pool an empty block still fits at offset zero, but a single byte
        // does not.
        add_pool_write(17'd0);
        add_request(OP_CREATE, 16'd0, 17'd0, 1'b1, make_answer(1, ST_OK, 1, 0, 0));
        add_request(OP_CREATE, 16'd0, 17'd1, 1'b1, make_answer(0, ST_NOSPACE, 0, 0, 0));
        // The largest register value must behave as the pool limit, so a create that would
        // end one byte past the limit is refused.
        add_pool_write(17'h1FFFF);
        add_request(OP_CREATE, 16'd0, 17'd100, 1'b1, make_answer(1, ST_OK, 2, 0, 0));
        add_request(OP_CREATE, 16'd0, 17'd65437, 1'b1, make_answer(0, ST_NOSPACE, 0, 0, 0));
        add_request(OP_XLATE, 16'd2, 17'd100, 1'b1, make_answer(1, ST_OK, 0, 0, 0));
        add_request(OP_XLATE, 16'd2, 17'd101, 1'b1, make_answer(0, ST_REFUSED, 0, 0, 0));
        add_request(OP_XLATE, 16'd0, 17'd1, 1'b1, make_answer(0, ST_REFUSED, 0, 0, 0));
        add_request(OP_DEC, 16'd0, 17'd0, 1'b1, make_answer(1, ST_OK, 0, 0, 0));
        add_request(OP_DEC, 16'd0, 17'd0, 1'b1, make_answer(0, ST_REFUSED, 0, 0, 0));
        add_request(OP_INC, 16'd1, 17'd0, 1'b1, make_answer(1, ST_OK, 0, 0, 0));
        add_request(OP_SWEEP, 16'd0, 17'd0, 1'b1, make_answer(1, ST_OK, 0, 0, 1));
        add_request(OP_XLATE, 16'd0, 17'd0, 1'b1, make_answer(0, ST_NOTFOUND, 0, 0, 0));
        // The empty entry freed by the sweep is taken over. The next block is appended
        // after the 100-byte block.
        add_request(OP_CREATE, 16'd0, 17'd0, 1'b1, make_answer(1, ST_OK, 3, 0, 0));
        add_request(OP_CREATE, 16'd0, 17'd50, 1'b1, make_answer(1, ST_OK, 4, 100, 0));
        add_request(OP_XLATE, 16'd4, 17'd50, 1'b1, make_answer(1, ST_OK, 0, 100, 0));
        // A smaller block reuses the freed 100-byte entry and keeps its full size.
        add_request(OP_DEC, 16'd2, 17'd0, 1'b0, '0);
        add_request(OP_SWEEP, 16'd0, 17'd0, 1'b0, '0);
        add_request(OP_CREATE, 16'd0, 17'd60, 1'b0, '0);
        add_request(OP_XLATE, 16'd5, 17'd100, 1'b0, '0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            if (script[i].pool_write)
                write_pool(script[i].bytes);
            else
                send_item(script[i].kind, script[i].ident, script[i].bytes,
                          script[i].known, script[i].want);
        end

        // The pool settings grow from phase to phase, so that each of them still leaves room
        // for appends. The last one allows blocks to run up to the end of the pool.
        phase_pool[0] = 17'd0;
        phase_pool[1] = 17'd600;
        phase_pool[2] = 17'd4000;
        phase_pool[3] = 17'($urandom_range(4001, 65534));
        phase_pool[4] = 17'd65535;
        phase_pool[5] = 17'h1FFFF;
        for (int p = 0; p < PHASES; p++)
        begin
            write_pool(phase_pool[p]);
            run_random(PHASE_ITEMS);
        end

        settle(SETTLE_CYCLES);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/rfbt_pkg.sv
src/rfbt_table.sv
src/rfbt_eval.sv
src/refcounted_first_fit_block_table_unit.sv
src/rfbt_checker.sv
verif/refcounted_first_fit_block_table_unit_tb.sv
